// ===== sv/rbv_pkg.sv =====
// ----------------------------------------------------------------------------
// rbv_pkg
// Shared sizes for the rank-by-value block.
// ----------------------------------------------------------------------------
`default_nettype none

package rbv_pkg;

	localparam int CAPACITY = 64;
	localparam int VAL_W    = 32;
	localparam int RANK_W   = 7;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

endpackage

`default_nettype wire

// ===== sv/rbv_if.sv =====
// ----------------------------------------------------------------------------
// rbv_in_if / rbv_out_if
// Valid/ready channels for input values and output ranks.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbv_in_if
	import rbv_pkg::*;
	();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] value;
	logic                    last_item;

	modport source (output valid, output value, output last_item, input ready);
	modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface rbv_out_if
	import rbv_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [RANK_W-1:0] rank;
	logic              final_rank;
	logic              overflow;

	modport source (output valid, output rank, output final_rank, output overflow,
		input ready);
	modport sink   (input valid, input rank, input final_rank, input overflow,
		output ready);
endinterface

`default_nettype wire

// ===== sv/rbv_ram.sv =====
// ----------------------------------------------------------------------------
// rbv_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rbv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                                      clk,
	input  wire logic                                      wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                          wr_data,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output      logic [WIDTH-1:0]                          rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

// ===== sv/rank_by_value_top.sv =====
// ----------------------------------------------------------------------------
// rank_by_value_top
// Rank transform of a set of signed values by comparison sweeps.
// ----------------------------------------------------------------------------
// Values are taken one per cycle and written to a CAPACITY-entry RAM; values
// beyond CAPACITY are dropped and flagged as overflow. The transaction with
// last_item set closes the set, and the block then emits one rank per stored
// value in input order (1 = smallest, ties ranked higher for the earlier
// value). Each rank comes from a sweep of one comparator over all n stored
// values through the single RAM read port: the value's own key is read first,
// then each stored value is compared with it, and the rank is then held until
// the output is taken. No input is accepted while ranks are being produced.
// ----------------------------------------------------------------------------
`default_nettype none

module rank_by_value_top
	import rbv_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	rbv_in_if.sink       in_ch,
	rbv_out_if.source    out_ch
);

	typedef enum logic [2:0] {
		S_LOAD,
		S_RDI,
		S_KEY,
		S_CMP,
		S_OUT
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    ovf_q;
	logic [IDX_W-1:0]        nm1_q;
	logic [IDX_W-1:0]        i_q;
	logic [IDX_W-1:0]        jd_q;
	logic [RANK_W-1:0]       rank_q;
	logic signed [VAL_W-1:0] ki_q;

	logic                    in_acc;
	logic                    full;
	logic                    wr_en;
	logic [IDX_W-1:0]        rd_addr;
	logic [VAL_W-1:0]        rd_data;
	logic signed [VAL_W-1:0] kj;
	logic                    cnt_inc;
	logic [CNT_W-1:0]        cnt_new;
	logic                    is_final;

	assign in_acc  = in_ch.valid && in_ch.ready;
	assign full    = (cnt_q >= CNT_W'(CAPACITY));
	assign wr_en   = in_acc && !full;
	assign cnt_new = full ? cnt_q : cnt_q + CNT_W'(1);
	assign kj      = $signed(rd_data);
	assign cnt_inc = (kj < ki_q) || ((kj == ki_q) && (jd_q > i_q));
	assign is_final = (i_q == nm1_q);

	assign in_ch.ready      = (state_q == S_LOAD);
	assign out_ch.valid     = (state_q == S_OUT);
	assign out_ch.rank      = rank_q;
	assign out_ch.final_rank = is_final;
	assign out_ch.overflow  = ovf_q;

	always_comb begin
		unique case (state_q)
			S_RDI:   rd_addr = i_q;
			S_KEY:   rd_addr = '0;
			S_CMP:   rd_addr = jd_q + IDX_W'(1);
			default: rd_addr = i_q;
		endcase
	end

	rbv_ram #(
		.WIDTH (VAL_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cnt_q[IDX_W-1:0]),
		.wr_data (in_ch.value),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			nm1_q   <= '0;
			i_q     <= '0;
			jd_q    <= '0;
			rank_q  <= '0;
			ki_q    <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						cnt_q <= cnt_new;
						if (full) begin
							ovf_q <= 1'b1;
						end
						if (in_ch.last_item) begin
							nm1_q   <= IDX_W'(cnt_new - CNT_W'(1));
							i_q     <= '0;
							state_q <= S_RDI;
						end
					end
				end
				S_RDI: begin
					state_q <= S_KEY;
				end
				S_KEY: begin
					ki_q    <= $signed(rd_data);
					jd_q    <= '0;
					rank_q  <= RANK_W'(1);
					state_q <= S_CMP;
				end
				S_CMP: begin
					rank_q <= rank_q + RANK_W'(cnt_inc);
					jd_q   <= jd_q + IDX_W'(1);
					if (jd_q == nm1_q) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_ch.ready) begin
						if (is_final) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							i_q     <= i_q + IDX_W'(1);
							state_q <= S_RDI;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
